// ===== rtl/bfvcd_pkg.sv =====
// Shared definitions for the BFV coefficient decode block.
// Field widths, register map codes and register reset values; no dependencies.
package bfvcd_pkg;

  // Port field widths
  localparam int unsigned DATA_WIDTH       = 64;
  localparam int unsigned HALF_DELTA_WIDTH = 63;
  localparam int unsigned CFG_INDEX_WIDTH  = 3;

  // Default datapath width
  localparam int unsigned DEF_COEFF_WIDTH  = 64;

  // Register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COEFF_MODULUS   = 3'd0,
    REG_DELTA           = 3'd1,
    REG_HALF_DELTA      = 3'd2,
    REG_UPPER_THRESHOLD = 3'd3,
    REG_UPPER_INCREMENT = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam logic [DATA_WIDTH-1:0]       RST_COEFF_MODULUS   = 64'd2;
  localparam logic [DATA_WIDTH-1:0]       RST_DELTA           = 64'd1;
  localparam logic [HALF_DELTA_WIDTH-1:0] RST_HALF_DELTA      = 63'd0;
  localparam logic [DATA_WIDTH-1:0]       RST_UPPER_THRESHOLD = 64'd1;
  localparam logic [DATA_WIDTH-1:0]       RST_UPPER_INCREMENT = 64'd0;

endpackage

// ===== rtl/bfv_coefficient_decode.sv =====
// BFV decryption scale-and-round: one phase coefficient in, one plaintext coefficient out.
// Depends on bfvcd_pkg for widths, register codes and reset values.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / phase_coeff_i) carries one phase
//   coefficient per transfer; output channel (out_valid_o / out_stall_i /
//   plain_coeff_o) returns exactly one plaintext coefficient per input, in order.
//   Configuration port (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
//   writes q, delta, half_delta, upper_threshold and upper_increment by index;
//   it is always ready, indexes past the register map are dropped. Write it only
//   while no coefficient is in flight.
//   Datapath: modular add, upper-half correction, then a restoring divider with
//   one quotient bit per stage. Throughput is one coefficient per cycle while
//   in_stall_o is low, set by the one-bit-per-stage divider pipeline.
//   The result sits in an output register backed by a one-entry skid buffer.
//   When the receiver stalls, the pipeline keeps taking input until the skid
//   buffer fills; in_stall_o then rises and the whole pipeline freezes, so
//   nothing is lost or repeated. in_stall_o comes straight from a register.
//   Reset clears all valid bits and loads the register reset values.
module bfv_coefficient_decode #(
  parameter int unsigned COEFF_WIDTH = bfvcd_pkg::DEF_COEFF_WIDTH
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [bfvcd_pkg::DATA_WIDTH-1:0]        phase_coeff_i,
  // output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [bfvcd_pkg::DATA_WIDTH-1:0]        plain_coeff_o,
  // configuration write channel
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [bfvcd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  logic [bfvcd_pkg::DATA_WIDTH-1:0]        cfg_data_i
);

  localparam int unsigned W = COEFF_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       coeff_modulus_q;
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       delta_q;
  logic [bfvcd_pkg::HALF_DELTA_WIDTH-1:0] half_delta_q;
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       upper_threshold_q;
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       upper_increment_q;
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       half_delta_ext;

  assign cfg_ready_o = 1'b1;

  // Write the addressed register; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_modulus_q   <= bfvcd_pkg::RST_COEFF_MODULUS;
      delta_q           <= bfvcd_pkg::RST_DELTA;
      half_delta_q      <= bfvcd_pkg::RST_HALF_DELTA;
      upper_threshold_q <= bfvcd_pkg::RST_UPPER_THRESHOLD;
      upper_increment_q <= bfvcd_pkg::RST_UPPER_INCREMENT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bfvcd_pkg::cfg_reg_e'(cfg_index_i))
        bfvcd_pkg::REG_COEFF_MODULUS:   coeff_modulus_q   <= cfg_data_i;
        bfvcd_pkg::REG_DELTA:           delta_q           <= cfg_data_i;
        bfvcd_pkg::REG_HALF_DELTA:
          half_delta_q <= cfg_data_i[bfvcd_pkg::HALF_DELTA_WIDTH-1:0];
        bfvcd_pkg::REG_UPPER_THRESHOLD: upper_threshold_q <= cfg_data_i;
        bfvcd_pkg::REG_UPPER_INCREMENT: upper_increment_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cut every register to the datapath width
  logic [W-1:0] q_w, d_w, hd_w, thr_w, inc_w;
  assign half_delta_ext = bfvcd_pkg::DATA_WIDTH'(half_delta_q);
  assign q_w   = coeff_modulus_q[W-1:0];
  assign d_w   = delta_q[W-1:0];
  assign hd_w  = half_delta_ext[W-1:0];
  assign thr_w = upper_threshold_q[W-1:0];
  assign inc_w = upper_increment_q[W-1:0];

  // ---------------------------------------------------------------------------
  // Pipeline enable: freeze everything while the skid buffer holds an item
  // ---------------------------------------------------------------------------
  logic skid_vld_q;
  logic pipe_en;

  assign pipe_en    = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // ---------------------------------------------------------------------------
  // Stages 0..2: add half delta mod q, then upper-half correction
  // ---------------------------------------------------------------------------
  logic         add_vld_q, mod_vld_q, cor_vld_q;
  logic [W:0]   add_sum_q;
  logic [W-1:0] mod_val_q, cor_val_q;
  logic [W:0]   add_sum_d;
  logic [W-1:0] mod_val_d, cor_val_d;

  always_comb begin
    add_sum_d = {1'b0, phase_coeff_i[W-1:0]} + {1'b0, hd_w};
    // subtract q on carry out or when the sum reaches q
    if (add_sum_q >= {1'b0, q_w}) begin
      mod_val_d = add_sum_q[W-1:0] - q_w;
    end else begin
      mod_val_d = add_sum_q[W-1:0];
    end
    // pull upper-half values down by q - t*delta
    if (mod_val_q >= thr_w) begin
      cor_val_d = mod_val_q - inc_w;
    end else begin
      cor_val_d = mod_val_q;
    end
  end

  // Advance front-stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_vld_q <= 1'b0;
      mod_vld_q <= 1'b0;
      cor_vld_q <= 1'b0;
    end else if (pipe_en) begin
      add_vld_q <= in_valid_i;
      mod_vld_q <= add_vld_q;
      cor_vld_q <= mod_vld_q;
    end
  end

  // Advance front-stage payload
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      add_sum_q <= add_sum_d;
      mod_val_q <= mod_val_d;
      cor_val_q <= cor_val_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, MSB first. The dividend
  // shifts out of the top of dq while quotient bits shift in at the bottom.
  // A zero divisor sets every quotient bit, giving all ones.
  // ---------------------------------------------------------------------------
  logic         div_vld_q [W];
  logic [W-1:0] div_dq_q  [W];
  logic [W-1:0] div_rem_q [W-1];

  for (genvar k = 0; k < W; k++) begin : g_div
    logic         vld_in;
    logic [W-1:0] dq_in;
    logic [W-1:0] rem_in;
    logic [W:0]   trial;
    logic         ge;
    logic [W-1:0] rem_d;
    logic [W-1:0] dq_d;

    if (k == 0) begin : g_first
      assign vld_in = cor_vld_q;
      assign dq_in  = cor_val_q;
      assign rem_in = '0;
    end else begin : g_next
      assign vld_in = div_vld_q[k-1];
      assign dq_in  = div_dq_q[k-1];
      assign rem_in = div_rem_q[k-1];
    end

    always_comb begin
      trial = {rem_in, dq_in[W-1]};
      ge    = trial >= {1'b0, d_w};
      if (ge) begin
        rem_d = W'(trial - {1'b0, d_w});
      end else begin
        rem_d = trial[W-1:0];
      end
      dq_d = {dq_in[W-2:0], ge};
    end

    // Advance this stage's valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k] <= 1'b0;
      end else if (pipe_en) begin
        div_vld_q[k] <= vld_in;
      end
    end

    // Advance this stage's payload
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        div_dq_q[k] <= dq_d;
      end
    end

    // The last stage needs no remainder
    if (k < W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          div_rem_q[k] <= rem_d;
        end
      end
    end else begin : g_norem
      logic unused_rem;
      assign unused_rem = ^rem_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid buffer
  // ---------------------------------------------------------------------------
  logic         out_vld_q;
  logic [W-1:0] out_q, skid_q;
  logic         out_take;
  logic         arr_vld;
  logic [W-1:0] arr_val;

  assign out_take = out_vld_q && !out_stall_i;
  assign arr_vld  = div_vld_q[W-1];
  assign arr_val  = div_dq_q[W-1];

  // Hold, refill from skid, or catch the arriving item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_take) begin
      out_vld_q <= arr_vld;
    end else if (arr_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_take) begin
      out_q <= arr_val;
    end else begin
      skid_q <= arr_val;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign plain_coeff_o = bfvcd_pkg::DATA_WIDTH'(out_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_implies_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q
  ) else $error("skid buffer holds an item while output register is empty");

  a_skid_fill_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i && arr_vld)
  ) else $error("skid buffer filled without a stalled output and an arriving item");

  a_skid_drain: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && out_take) |=> (out_vld_q && !skid_vld_q && out_q == $past(skid_q))
  ) else $error("skid buffer item not moved into output register");

  a_frozen_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(div_vld_q[W-1]) && $stable(add_vld_q)
  ) else $error("pipeline advanced while skid buffer was full");

endmodule

// ===== test/bfvcd_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the BFV coefficient decode block: it tracks register writes,
// predicts each plaintext coefficient and compares the results in order.
// Depends on bfvcd_pkg for field widths, register codes and reset values.
module bfvcd_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic [bfvcd_pkg::DATA_WIDTH-1:0]      phase_coeff_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic [bfvcd_pkg::DATA_WIDTH-1:0]      plain_coeff_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [bfvcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [bfvcd_pkg::DATA_WIDTH-1:0]      cfg_data_i,
  output int                                    error_count_o,
  output int                                    pending_o,
  output int                                    checked_o
);

  // Shadow copy of the register file
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       modulus;
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       scale;
  logic [bfvcd_pkg::HALF_DELTA_WIDTH-1:0] rounding;
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       threshold;
  logic [bfvcd_pkg::DATA_WIDTH-1:0]       increment;

  logic [bfvcd_pkg::DATA_WIDTH-1:0] plain_coeff_queue[$];
  int                               error_count;
  int                               checked_count;

  // Add the rounding offset modulo q, fold the upper half, divide by delta
  function automatic logic [bfvcd_pkg::DATA_WIDTH-1:0] scale_and_round(
    input logic [bfvcd_pkg::DATA_WIDTH-1:0] phase
  );
    logic [bfvcd_pkg::DATA_WIDTH:0]   wide_sum;
    logic [bfvcd_pkg::DATA_WIDTH-1:0] lifted;
    wide_sum = {1'b0, phase} + {2'b00, rounding};
    lifted   = wide_sum[bfvcd_pkg::DATA_WIDTH-1:0];
    if (wide_sum[bfvcd_pkg::DATA_WIDTH] || lifted >= modulus) lifted = lifted - modulus;
    if (lifted >= threshold) lifted = lifted - increment;
    if (scale == '0) return '1;
    return lifted / scale;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [bfvcd_pkg::DATA_WIDTH-1:0] want;
    if (!rst_ni) begin
      modulus   = bfvcd_pkg::RST_COEFF_MODULUS;
      scale     = bfvcd_pkg::RST_DELTA;
      rounding  = bfvcd_pkg::RST_HALF_DELTA;
      threshold = bfvcd_pkg::RST_UPPER_THRESHOLD;
      increment = bfvcd_pkg::RST_UPPER_INCREMENT;
      plain_coeff_queue.delete();
      error_count   = 0;
      checked_count = 0;
      error_count_o <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
    end else begin
      // Track register writes; unmapped indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bfvcd_pkg::REG_COEFF_MODULUS:   modulus   = cfg_data_i;
          bfvcd_pkg::REG_DELTA:           scale     = cfg_data_i;
          bfvcd_pkg::REG_HALF_DELTA:
            rounding = cfg_data_i[bfvcd_pkg::HALF_DELTA_WIDTH-1:0];
          bfvcd_pkg::REG_UPPER_THRESHOLD: threshold = cfg_data_i;
          bfvcd_pkg::REG_UPPER_INCREMENT: increment = cfg_data_i;
          default: ;
        endcase
      end

      // Predict on every input transfer
      if (in_valid_i && !in_stall_i) begin
        plain_coeff_queue.push_back(scale_and_round(phase_coeff_i));
      end

      // Compare every output transfer with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (plain_coeff_queue.size() == 0) begin
          $error("plain_coeff: unexpected result, expected none, actual 0x%h",
                 plain_coeff_i);
          error_count++;
        end else begin
          want = plain_coeff_queue.pop_front();
          checked_count++;
          if (plain_coeff_i !== want) begin
            $error("plain_coeff: expected 0x%h, actual 0x%h", want, plain_coeff_i);
            error_count++;
          end
        end
      end

      error_count_o <= error_count;
      pending_o     <= plain_coeff_queue.size();
      checked_o     <= checked_count;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the BFV coefficient decode testbench: clock, reset, register settings,
// coefficient stimulus and verdict. Depends on bfvcd_pkg, the block and bfvcd_checker.
module testbench;

  localparam int unsigned LATENCY     = bfvcd_pkg::DEF_COEFF_WIDTH + 4;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          CHUNK       = 50;
  localparam int unsigned IDX_W       = bfvcd_pkg::CFG_INDEX_WIDTH;
  localparam int unsigned DW          = bfvcd_pkg::DATA_WIDTH;
  localparam logic [IDX_W-1:0] FIRST_UNUSED_INDEX =
    IDX_W'(bfvcd_pkg::REG_UPPER_INCREMENT + 1);
  localparam logic [IDX_W-1:0] LAST_UNUSED_INDEX  = '1;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid      = 1'b0;
  logic [DW-1:0]    phase_coeff   = '0;
  logic             out_stall     = 1'b0;
  logic             cfg_valid     = 1'b0;
  logic [IDX_W-1:0] cfg_index     = '0;
  logic [DW-1:0]    cfg_data      = '0;
  logic             in_stall;
  logic             out_valid;
  logic [DW-1:0]    plain_coeff;
  logic             cfg_ready;

  int error_count;
  int pending;
  int checked;
  int cycle_count    = 0;
  int sent_count     = 0;
  int settings_count = 0;
  int gap_pct        = 0;
  int stall_pct      = 0;

  // Current register values, used to aim stimulus at boundaries
  logic [DW-1:0] cur_q   = bfvcd_pkg::RST_COEFF_MODULUS;
  logic [DW-1:0] cur_d   = bfvcd_pkg::RST_DELTA;
  logic [DW-1:0] cur_hd  = '0;
  logic [DW-1:0] cur_thr = bfvcd_pkg::RST_UPPER_THRESHOLD;

  bfv_coefficient_decode dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .phase_coeff_i(phase_coeff),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .plain_coeff_o(plain_coeff),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  bfvcd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .phase_coeff_i(phase_coeff),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .plain_coeff_i(plain_coeff),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .error_count_o(error_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Give up after a generous number of cycles
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Drop valid and wait until every result is back, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Hold one register write until it transfers; the caller lowers valid
  task automatic write_reg(input logic [IDX_W-1:0] index,
                           input logic [DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [DW-1:0] q, input logic [DW-1:0] d,
                               input logic [DW-1:0] hd,
                               input logic [DW-1:0] thr,
                               input logic [DW-1:0] inc);
    wait_idle();
    write_reg(bfvcd_pkg::REG_COEFF_MODULUS, q);
    write_reg(bfvcd_pkg::REG_DELTA, d);
    write_reg(bfvcd_pkg::REG_HALF_DELTA, hd);
    // unmapped index in the middle must leave everything untouched
    write_reg(IDX_W'($urandom_range(LAST_UNUSED_INDEX, FIRST_UNUSED_INDEX)),
              {$urandom, $urandom});
    write_reg(bfvcd_pkg::REG_UPPER_THRESHOLD, thr);
    write_reg(bfvcd_pkg::REG_UPPER_INCREMENT, inc);
    cfg_valid <= 1'b0;
    cur_q   = q;
    cur_d   = d;
    cur_hd  = {1'b0, hd[bfvcd_pkg::HALF_DELTA_WIDTH-1:0]};
    cur_thr = thr;
    settings_count++;
  endtask

  // Consistent register set for modulus q and plaintext modulus t
  task automatic apply_scheme(input logic [DW-1:0] q, input logic [DW-1:0] t);
    logic [DW-1:0] d;
    d = q / t;
    apply_setting(q, d, d >> 1, (q >> 1) + q[0], q - t * d);
  endtask

  // Send one coefficient, with random gaps according to the current idle phase
  task automatic send_coeff(input logic [DW-1:0] x);
    case ((sent_count / CHUNK) % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 78; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 78; end
      default: begin gap_pct = 37; stall_pct = 37; end
    endcase
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    phase_coeff <= x;
    do @(posedge clk_i); while (in_stall);
    sent_count++;
  endtask

  // Mostly reduced phases, some raw, some on the rounding and quotient edges
  function automatic logic [DW-1:0] next_phase();
    logic [DW-1:0] r;
    int            pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 55 && cur_q != '0) return r % cur_q;
    if (pick < 70) return r;
    if (pick < 85) return cur_thr - cur_hd - 2 + $urandom_range(4);
    if (cur_d != '0 && cur_q != '0) return (r % cur_q) / cur_d * cur_d - 1 + $urandom_range(2);
    return r;
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_coeff(next_phase());
  endtask

  initial begin
    logic [DW-1:0] directed[$];
    logic [DW-1:0] q;
    logic [DW-1:0] t;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values
    send_random(60);

    // Directed: field extremes, phases at and above q, carry out of the add,
    // both sides of the upper half boundary and of quotient steps
    apply_scheme(64'hFFFF_FFFF_FFFF_FFC5, 256);
    directed = '{'0, 1, '1, cur_q - 1, cur_q, cur_q + 1,
                 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 cur_thr - cur_hd - 1, cur_thr - cur_hd, cur_thr - cur_hd + 1,
                 cur_q - cur_hd - 1, cur_q - cur_hd, cur_q - cur_hd + 1,
                 cur_d - 1, cur_d, cur_d + cur_hd, 2 * cur_d - cur_hd - 1};
    foreach (directed[i]) send_coeff(directed[i]);
    send_random(200);

    // Largest and smallest modulus, a small prime modulus
    apply_scheme('1, 2);
    send_random(150);
    apply_scheme(2, 2);
    send_random(60);
    apply_scheme(97, 7);
    send_random(150);

    // Register extremes; half delta written with its dropped top bit set
    apply_setting('1, 64'h8000_0000_0000_0000, 64'hC000_0000_0000_0000,
                  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_random(150);

    // Zero delta: the divider saturates
    q = {$urandom, $urandom};
    apply_setting(q, '0, {$urandom, $urandom}, (q >> 1) + q[0], {$urandom, $urandom});
    send_random(80);

    // Inconsistent registers: the upper half correction wraps below zero
    apply_setting(100, 7, 3, 10, 50);
    send_random(100);

    // Zero modulus and zero threshold
    apply_setting('0, 3, 1, '0, '0);
    send_random(40);

    // Random schemes, one with t = 1
    for (int k = 0; k < 4; k++) begin
      q = (k == 0) ? $urandom_range(65535, 2) : {$urandom, $urandom};
      if (q < 2) q = 2;
      t = (k == 1) ? 1 : $urandom_range(65536, 2);
      if (t > q) t = q;
      apply_scheme(q, t);
      send_random(125);
    end

    wait_idle();
    $display("Sent %0d phase coefficients under %0d register settings; %0d results compared.",
             sent_count, settings_count, checked);
    if (error_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bfvcd_pkg.sv
rtl/bfv_coefficient_decode.sv
test/bfvcd_checker.sv
test/testbench.sv
